@@ src/sca_pkg.sv @@
// Shared types, constants and helpers for the size-class free-list allocator.
`default_nettype none

package sca_pkg;

    localparam int BLOCKS_PER_CLASS = 32;
    localparam int CLASS_COUNT      = 16;
    localparam int CLASS_STEP_BYTES = 8;

    localparam int TOTAL_BLOCKS = CLASS_COUNT * BLOCKS_PER_CLASS;
    localparam int MAX_BYTES    = CLASS_COUNT * CLASS_STEP_BYTES;

    localparam int HANDLE_W = 9;
    localparam int SIZE_W   = 16;
    localparam int CLASS_W  = 4;
    localparam int BYTES_W  = 8;
    localparam int COUNT_W  = 6;
    localparam int SLOT_W   = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
    localparam int ADDR_W   = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_FREE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REJECT = 2'd2
    } op_kind_t;

    // Decoded item passed from the front end to the back end
    typedef struct packed {
        op_kind_t              kind;
        logic [CLASS_W-1:0]    cls;
        logic [BYTES_W-1:0]    bytes;
        logic [HANDLE_W-1:0]   handle;
        status_t               status;
    } op_t;

    // Result word as it leaves the block
    typedef struct packed {
        logic [COUNT_W-1:0]    free_left;
        logic [BYTES_W-1:0]    block_bytes;
        logic [CLASS_W-1:0]    size_class;
        status_t               status;
        logic [HANDLE_W-1:0]   block_handle;
    } result_t;

    // Block size of a class
    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
        return BYTES_W'((int'(c) + 1) * CLASS_STEP_BYTES);
    endfunction

    // Reset value of a link word: previous slot of the class, slot 0 to itself
    function automatic logic [HANDLE_W-1:0] init_link(input logic [ADDR_W-1:0] idx);
        logic [HANDLE_W-1:0] h;
        h = HANDLE_W'(idx);
        if ((int'(idx) % BLOCKS_PER_CLASS) == 0)
            return h;
        return h - HANDLE_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ src/size_class_free_list_allocator_unit.sv @@
// Top level of the size-class free-list allocator.
// Path: a free, an empty-class or a rejected item passes the queue register and then the
// result register; a successful allocate also passes BK_LINK for the link memory read.
// Throughput: one item a cycle while the receiver takes results, except a successful
// allocate, which holds the back end in BK_LINK on the registered read of the link memory.
// Reset: heads and counts return to full pools at once; the link memory is then swept,
// one word a cycle over the whole memory, during which s_axis_tready stays low.
`default_nettype none

module size_class_free_list_allocator_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] request_size, [24:16] handle, [31:25] zero
    input  wire logic [sca_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] command (0 allocate, 1 free)
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [8:0] block_handle, [10:9] status, [14:11] size_class, [22:15] block_bytes,
    // [28:23] free_left, [31:29] zero
    output logic [sca_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    logic              init_done;
    logic              q_ready, q_push, q_valid, q_pop;
    sca_pkg::op_t      push_op, head_op;
    sca_pkg::result_t  result;

    // Front end: decode size to class, split handle, flag requests out of range
    sca_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .init_done     (init_done),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_data        (push_op)
    );

    // Decouple the two sides so each can stall on its own
    sca_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_op),
        .ready     (q_ready),
        .valid     (q_valid),
        .data      (head_op),
        .pop       (q_pop)
    );

    // Back end: pop or push the class list and register the result
    sca_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (head_op),
        .q_pop     (q_pop),
        .init_done (init_done),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    // Pack the result item, last declared field (block_handle) in the lowest bits
    assign m_axis_tdata = sca_pkg::OUT_DATA_W'(result);

endmodule

`default_nettype wire

@@ src/sca_front.sv @@
// Front end: take items from the input stream and decode them into operations.
`default_nettype none

module sca_front (
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [sca_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tuser,
    input  wire logic                            init_done,
    input  wire logic                            q_ready,
    output logic                                 q_push,
    output sca_pkg::op_t                         q_data
);

    logic [sca_pkg::SIZE_W-1:0]   size;
    logic [sca_pkg::HANDLE_W-1:0] h;
    logic [sca_pkg::CLASS_W-1:0]  cls;

    assign size = s_axis_tdata[sca_pkg::SIZE_W-1:0];
    assign h    = s_axis_tdata[sca_pkg::SIZE_W +: sca_pkg::HANDLE_W];

    // hold input off until the link memory is initialised
    assign s_axis_tready = q_ready && init_done;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cls    = '0;
        q_data = '0;
        if (s_axis_tuser != sca_pkg::CMD_FREE)
        begin
            if ({1'b0, size} > (sca_pkg::SIZE_W+1)'(sca_pkg::MAX_BYTES))
            begin
                q_data.kind   = sca_pkg::OP_REJECT;
                q_data.status = sca_pkg::ST_TOO_LARGE;
            end
            else
            begin
                // round up to the step; size zero maps to the smallest class
                if (size != '0)
                    cls = sca_pkg::CLASS_W'((size - sca_pkg::SIZE_W'(1))
                                            / sca_pkg::CLASS_STEP_BYTES);
                q_data.kind   = sca_pkg::OP_ALLOC;
                q_data.cls    = cls;
                q_data.bytes  = sca_pkg::class_bytes(cls);
                q_data.status = sca_pkg::ST_OK;
            end
        end
        else
        begin
            q_data.handle = h;
            if ({1'b0, h} >= (sca_pkg::HANDLE_W+1)'(sca_pkg::TOTAL_BLOCKS))
            begin
                q_data.kind   = sca_pkg::OP_REJECT;
                q_data.status = sca_pkg::ST_IGNORED;
            end
            else
            begin
                cls           = sca_pkg::CLASS_W'(h / sca_pkg::BLOCKS_PER_CLASS);
                q_data.kind   = sca_pkg::OP_FREE;
                q_data.cls    = cls;
                q_data.bytes  = sca_pkg::class_bytes(cls);
                q_data.status = sca_pkg::ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/sca_queue.sv @@
// Short queue of decoded operations between front end and back end.
`default_nettype none

module sca_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire sca_pkg::op_t push_data,
    output logic              ready,
    output logic              valid,
    output sca_pkg::op_t      data,
    input  wire logic         pop
);

    sca_pkg::op_t                  entry_reg [sca_pkg::QUEUE_DEPTH];
    logic [sca_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sca_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sca_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    assign ready = (cnt_reg != sca_pkg::QCNT_W'(sca_pkg::QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == sca_pkg::QPTR_W'(sca_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + sca_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == sca_pkg::QPTR_W'(sca_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + sca_pkg::QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + sca_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - sca_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ src/sca_back.sv @@
// Back end: list heads, counts, link memory and the result register.
`default_nettype none

module sca_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire sca_pkg::op_t  q_data,
    output logic               q_pop,
    output logic               init_done,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sca_pkg::result_t   out_data
);

    typedef enum logic [2:0] {
        BK_CLEAR = 3'b001,
        BK_RUN   = 3'b010,
        BK_LINK  = 3'b100
    } bk_state_t;

    bk_state_t                      state_reg, state_next;
    logic [sca_pkg::ADDR_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [sca_pkg::HANDLE_W-1:0]   head_reg  [sca_pkg::CLASS_COUNT];
    logic [sca_pkg::HANDLE_W-1:0]   head_next [sca_pkg::CLASS_COUNT];
    logic [sca_pkg::COUNT_W-1:0]    count_reg [sca_pkg::CLASS_COUNT];
    logic [sca_pkg::COUNT_W-1:0]    count_next[sca_pkg::CLASS_COUNT];

    logic                           out_valid_reg, out_valid_next;
    sca_pkg::result_t               out_data_reg, out_data_next;
    logic [sca_pkg::CLASS_W-1:0]    pend_cls_reg, pend_cls_next;
    logic [sca_pkg::BYTES_W-1:0]    pend_bytes_reg, pend_bytes_next;
    logic [sca_pkg::HANDLE_W-1:0]   pend_blk_reg, pend_blk_next;

    logic [sca_pkg::HANDLE_W-1:0]   link_mem [sca_pkg::TOTAL_BLOCKS];
    logic [sca_pkg::HANDLE_W-1:0]   rd_data_reg;
    logic                           mem_we, mem_re;
    logic [sca_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [sca_pkg::HANDLE_W-1:0]   mem_wdata;

    logic                           slot_free;
    logic [sca_pkg::HANDLE_W-1:0]   cur_head;
    logic [sca_pkg::COUNT_W-1:0]    cur_count;
    logic [sca_pkg::COUNT_W-1:0]    new_count;

    assign init_done = (state_reg != BK_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign cur_head  = head_reg[q_data.cls];
    assign cur_count = count_reg[q_data.cls];

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        pend_cls_next   = pend_cls_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_blk_next   = pend_blk_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = '0;
        q_pop           = 1'b0;
        new_count       = '0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                // sweep the link memory to its reset contents
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = sca_pkg::init_link(clr_idx_reg);
                clr_idx_next = clr_idx_reg + sca_pkg::ADDR_W'(1);
                if (clr_idx_reg == sca_pkg::ADDR_W'(sca_pkg::TOTAL_BLOCKS - 1))
                    state_next = BK_RUN;
            end
            BK_RUN:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_data.kind)
                        sca_pkg::OP_ALLOC:
                        begin
                            if (cur_count == '0)
                            begin
                                out_valid_next              = 1'b1;
                                out_data_next               = '0;
                                out_data_next.status        = sca_pkg::ST_EMPTY;
                                out_data_next.size_class    = q_data.cls;
                                out_data_next.block_bytes   = q_data.bytes;
                            end
                            else
                            begin
                                // fetch the link of the head block, finish next cycle
                                mem_re          = 1'b1;
                                mem_raddr       = sca_pkg::ADDR_W'(cur_head);
                                pend_cls_next   = q_data.cls;
                                pend_bytes_next = q_data.bytes;
                                pend_blk_next   = cur_head;
                                state_next      = BK_LINK;
                            end
                        end
                        sca_pkg::OP_FREE:
                        begin
                            out_valid_next            = 1'b1;
                            out_data_next.block_handle = q_data.handle;
                            out_data_next.size_class  = q_data.cls;
                            out_data_next.block_bytes = q_data.bytes;
                            if (cur_count != '0 && cur_head == q_data.handle)
                            begin
                                // block is already the head: drop the free
                                out_data_next.status    = sca_pkg::ST_IGNORED;
                                out_data_next.free_left = cur_count;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = sca_pkg::ADDR_W'(q_data.handle);
                                mem_wdata = cur_head;
                                head_next[q_data.cls] = q_data.handle;
                                new_count = cur_count;
                                if (cur_count < sca_pkg::COUNT_W'(sca_pkg::BLOCKS_PER_CLASS))
                                    new_count = cur_count + sca_pkg::COUNT_W'(1);
                                count_next[q_data.cls]  = new_count;
                                out_data_next.status    = sca_pkg::ST_OK;
                                out_data_next.free_left = new_count;
                            end
                        end
                        default:
                        begin
                            out_valid_next             = 1'b1;
                            out_data_next              = '0;
                            out_data_next.block_handle = q_data.handle;
                            out_data_next.status       = q_data.status;
                            out_data_next.size_class   = q_data.cls;
                            out_data_next.block_bytes  = q_data.bytes;
                        end
                    endcase
                end
            end
            BK_LINK:
            begin
                // pop: the fetched link becomes the new head
                new_count = count_reg[pend_cls_reg] - sca_pkg::COUNT_W'(1);
                head_next[pend_cls_reg]    = rd_data_reg;
                count_next[pend_cls_reg]   = new_count;
                out_valid_next             = 1'b1;
                out_data_next.block_handle = pend_blk_reg;
                out_data_next.status       = sca_pkg::ST_OK;
                out_data_next.size_class   = pend_cls_reg;
                out_data_next.block_bytes  = pend_bytes_reg;
                out_data_next.free_left    = new_count;
                state_next                 = BK_RUN;
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < sca_pkg::CLASS_COUNT; c++)
            begin
                head_reg[c]  <= sca_pkg::HANDLE_W'(c * sca_pkg::BLOCKS_PER_CLASS
                                                   + sca_pkg::BLOCKS_PER_CLASS - 1);
                count_reg[c] <= sca_pkg::COUNT_W'(sca_pkg::BLOCKS_PER_CLASS);
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        pend_cls_reg   <= pend_cls_next;
        pend_bytes_reg <= pend_bytes_next;
        pend_blk_reg   <= pend_blk_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= link_mem[mem_raddr];
    end

endmodule

`default_nettype wire

@@ src/sca_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
`default_nettype none

module sca_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic [sca_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tuser,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [sca_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    sca_pkg::result_t res;
    assign res = sca_pkg::result_t'(m_axis_tdata[$bits(sca_pkg::result_t)-1:0]);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an oversized request carries no class, block or count
    a_too_large: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.status == sca_pkg::ST_TOO_LARGE |->
        res.block_handle == '0 && res.size_class == '0 &&
        res.block_bytes == '0 && res.free_left == '0)
        else $error("too-large result not cleared");

    // every other result names the block size of its class
    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.status != sca_pkg::ST_TOO_LARGE |->
        res.block_bytes == sca_pkg::class_bytes(res.size_class))
        else $error("block size does not match class");

    // a class never reports more free blocks than its pool
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        res.free_left <= sca_pkg::COUNT_W'(sca_pkg::BLOCKS_PER_CLASS))
        else $error("free count above pool depth");

    // input is not ready when reset is released, before the link memory is swept
    a_init: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input accepted during initialisation");

endmodule

bind size_class_free_list_allocator_unit sca_checker u_sca_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the size-class free-list allocator.
module tb;

    import sca_pkg::*;

    localparam logic CMD_ALLOC = ~CMD_FREE;

    // Two copies of the allocator state: one that plans the stimulus, one that
    // follows the items the block actually takes.
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    // Cycles with no handshake on either side before the run is abandoned; covers
    // the link memory sweep after reset, receiver stalls and sender gaps.
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_TICKS = 20;
    localparam int RANDOM_OPS  = 1800;

    typedef struct packed {
        logic                cmd;
        logic [SIZE_W-1:0]   req_size;
        logic [HANDLE_W-1:0] handle;
    } op_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] request_size, [24:16] handle
    logic                  s_axis_tuser = 1'b0; // [0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [8:0] handle, [10:9] status, [14:11] class,
                                                // [22:15] bytes, [28:23] free_left

    // Allocator state, one set per copy
    logic [HANDLE_W-1:0] link_mem [2][TOTAL_BLOCKS];
    logic [HANDLE_W-1:0] head_of  [2][CLASS_COUNT];
    logic [COUNT_W-1:0]  free_cnt [2][CLASS_COUNT];

    op_item_t            op_queue[$];        // items still to be offered
    result_t             awaited_results[$]; // outcomes of taken items, oldest first
    logic [HANDLE_W-1:0] live_blocks[$];     // handles the plan believes are handed out

    op_item_t    drive_op;
    op_item_t    taken_op;
    result_t     want;
    result_t     got;
    logic        in_took = 1'b0;
    int          burst_left = 12;
    int          gap_left = 0;
    logic [15:0] rx_tick = '0;
    int          rx_mode = 0;
    int          idle_cycles = 0;
    int          errors = 0;

    size_class_free_list_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Full pools: every slot links to the one below it, slot 0 to itself.
    task automatic pools_full(input int m);
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            for (int s = 0; s < BLOCKS_PER_CLASS; s++)
                link_mem[m][c * BLOCKS_PER_CLASS + s] =
                    HANDLE_W'(c * BLOCKS_PER_CLASS + ((s == 0) ? 0 : s - 1));
            head_of[m][c]  = HANDLE_W'(c * BLOCKS_PER_CLASS + BLOCKS_PER_CLASS - 1);
            free_cnt[m][c] = COUNT_W'(BLOCKS_PER_CLASS);
        end
    endtask

    // Apply one allocate or free to copy m and return what the block should report.
    function automatic result_t alloc_or_free(input int m, input op_item_t op);
        result_t             r;
        int unsigned         cls;
        logic [HANDLE_W-1:0] blk;
        r = '0;
        if (op.cmd == CMD_ALLOC)
        begin
            if (op.req_size > MAX_BYTES)
            begin
                r.status = ST_TOO_LARGE;
                return r;
            end
            // Round up to the class step; a zero-byte request lands in the smallest class
            cls = (op.req_size == 0) ? 0
                  : (int'(op.req_size) + CLASS_STEP_BYTES - 1) / CLASS_STEP_BYTES - 1;
            r.size_class  = CLASS_W'(cls);
            r.block_bytes = BYTES_W'((cls + 1) * CLASS_STEP_BYTES);
            if (free_cnt[m][cls] == 0)
            begin
                r.status = ST_EMPTY;
                return r;
            end
            blk              = head_of[m][cls];
            head_of[m][cls]  = link_mem[m][blk];
            free_cnt[m][cls] = free_cnt[m][cls] - 1'b1;
            r.block_handle   = blk;
            r.status         = ST_OK;
            r.free_left      = free_cnt[m][cls];
            return r;
        end
        r.block_handle = op.handle;
        if (int'(op.handle) >= TOTAL_BLOCKS)
        begin
            r.status = ST_IGNORED;
            return r;
        end
        cls           = op.handle / BLOCKS_PER_CLASS;
        r.size_class  = CLASS_W'(cls);
        r.block_bytes = BYTES_W'((cls + 1) * CLASS_STEP_BYTES);
        // Freeing the block already at the head of a non-empty list changes nothing
        if (free_cnt[m][cls] != 0 && head_of[m][cls] == op.handle)
        begin
            r.status    = ST_IGNORED;
            r.free_left = free_cnt[m][cls];
            return r;
        end
        // Anything else is pushed, even a block that is already free; the count saturates
        link_mem[m][op.handle] = head_of[m][cls];
        head_of[m][cls]        = op.handle;
        if (free_cnt[m][cls] < BLOCKS_PER_CLASS)
            free_cnt[m][cls] = free_cnt[m][cls] + 1'b1;
        r.status    = ST_OK;
        r.free_left = free_cnt[m][cls];
        return r;
    endfunction

    // Plan one item: run it on the planning copy, track handed-out blocks, queue it.
    task automatic queue_op(input logic cmd, input logic [SIZE_W-1:0] sz,
                            input logic [HANDLE_W-1:0] h);
        op_item_t op;
        result_t  r;
        op.cmd      = cmd;
        op.req_size = sz;
        op.handle   = h;
        r = alloc_or_free(PLAN, op);
        if (r.status == ST_OK)
        begin
            if (cmd == CMD_ALLOC)
                live_blocks.push_back(r.block_handle);
            else
                for (int i = 0; i < live_blocks.size(); i++)
                    if (live_blocks[i] == h)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
        end
        op_queue.push_back(op);
    endtask

    task automatic check_field(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    // Sender: offer queued items in bursts of random length, with random gaps between.
    // Hold an item until it is taken; only then move on.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_took)
            begin
                if (gap_left != 0 || op_queue.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    drive_op = op_queue.pop_front();
                    s_axis_tuser  <= drive_op.cmd;
                    s_axis_tdata  <= IN_DATA_W'({drive_op.handle, drive_op.req_size});
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        // a quarter of the bursts run straight on with no gap at all
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: switch between stall patterns whenever rx_tick[8:0] returns to zero; one of them never stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_tick[8:0] == '0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ((rx_tick % 13) < 4);
                default: m_axis_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Monitor: predict each taken item, then check each delivered result against the oldest
    // prediction. Prediction comes first so an item is always queued before its result.
    always @(posedge clk)
    begin
        in_took <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            taken_op.cmd      = s_axis_tuser;
            taken_op.req_size = s_axis_tdata[SIZE_W-1:0];
            taken_op.handle   = s_axis_tdata[SIZE_W +: HANDLE_W];
            awaited_results.push_back(alloc_or_free(LIVE, taken_op));
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(result_t)-1:0];
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("block_handle", want.block_handle, got.block_handle);
                check_field("status", int'(want.status), int'(got.status));
                check_field("size_class", want.size_class, got.size_class);
                check_field("block_bytes", want.block_bytes, got.block_bytes);
                check_field("free_left", want.free_left, got.free_left);
            end
        end
        // Watchdog: give up after too long with nothing moving on either side
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          random_ops;
        int          pick;
        int          n;
        int unsigned cls;
        int unsigned hot_cls;
        int          idx;
        random_ops = 0;
        hot_cls    = 0;
        pools_full(PLAN);
        pools_full(LIVE);

        // Directed: size boundaries, too large, both commands, field extremes
        queue_op(CMD_ALLOC, 16'd0, '0);            // zero bytes, smallest class
        queue_op(CMD_ALLOC, 16'd1, '0);
        queue_op(CMD_ALLOC, 16'd8, '0);
        queue_op(CMD_ALLOC, 16'd9, '0);            // first size of class 1
        queue_op(CMD_ALLOC, 16'd127, '0);
        queue_op(CMD_ALLOC, 16'd128, 9'h1FF);      // largest class, handle field ignored
        queue_op(CMD_ALLOC, 16'd129, '0);          // just too large
        queue_op(CMD_ALLOC, 16'hFFFF, 9'h1FF);
        queue_op(CMD_ALLOC, 16'h8000, '0);
        queue_op(CMD_ALLOC, 16'd64, 9'h155);
        queue_op(CMD_FREE, '0, 9'd31);             // hand back the first class-0 block
        queue_op(CMD_FREE, '0, head_of[PLAN][0]);  // current head: ignored
        queue_op(CMD_FREE, 16'hFFFF, 9'd0);        // already free, not the head
        queue_op(CMD_FREE, '0, 9'h100);            // full class: count saturates
        queue_op(CMD_FREE, 16'hAAAA, 9'h1FF);      // top handle back to the largest class
        queue_op(CMD_FREE, '0, 9'd510);
        queue_op(CMD_FREE, 16'h5555, 9'h0AA);
        queue_op(CMD_ALLOC, 16'd17, 9'h0AA);

        // Random: allocations, half of them in a favoured class, and frees of handed-out
        // blocks, with occasional drains that run a class dry, plus oversized requests and noise frees
        while (random_ops < RANDOM_OPS)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) == 0)
                hot_cls = $urandom_range(0, CLASS_COUNT - 1);
            if (pick < 2)
            begin
                cls = $urandom_range(0, CLASS_COUNT - 1);
                n   = free_cnt[PLAN][cls] + $urandom_range(1, 3);
                repeat (n)
                    queue_op(CMD_ALLOC,
                             SIZE_W'(cls * CLASS_STEP_BYTES + $urandom_range(1, CLASS_STEP_BYTES)),
                             HANDLE_W'($urandom));
                random_ops += n;
            end
            else
            begin
                if (pick < 45 || (pick < 80 && live_blocks.size() == 0))
                begin
                    if ($urandom_range(0, 1) == 1)
                        queue_op(CMD_ALLOC, SIZE_W'(hot_cls * CLASS_STEP_BYTES
                                                    + $urandom_range(1, CLASS_STEP_BYTES)),
                                 HANDLE_W'($urandom));
                    else
                        queue_op(CMD_ALLOC, SIZE_W'($urandom_range(0, MAX_BYTES)),
                                 HANDLE_W'($urandom));
                end
                else if (pick < 80)
                begin
                    idx = $urandom_range(0, live_blocks.size() - 1);
                    queue_op(CMD_FREE, SIZE_W'($urandom), live_blocks[idx]);
                end
                else if (pick < 88)
                    queue_op(CMD_ALLOC, SIZE_W'($urandom_range(MAX_BYTES + 1, 65535)),
                             HANDLE_W'($urandom));
                else if (pick < 96)
                    queue_op(CMD_FREE, SIZE_W'($urandom), HANDLE_W'($urandom));
                else
                    queue_op(CMD_FREE, SIZE_W'($urandom),
                             head_of[PLAN][$urandom_range(0, CLASS_COUNT - 1)]);
                random_ops++;
            end
        end

        // Release reset at a falling edge, away from the sampling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every item is taken and every result has come back, then idle a little
        while (op_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
